/* design/tpcd_pkg.sv */
`timescale 1ns / 1ps
// Terminal port command decoder: shared types and constants.
// No dependencies; imported by all modules.

package tpcd_pkg;

   // command bytes written in idle mode; CMD_RESET is taken in any mode
   localparam logic [7:0] CMD_RESET = 8'hFF;
   localparam logic [7:0] CMD_CUR_X = 8'h01;
   localparam logic [7:0] CMD_CUR_Y = 8'h02;
   localparam logic [7:0] CMD_CUR_V = 8'h03;
   localparam logic [7:0] CMD_PUT_C = 8'h04;
   localparam logic [7:0] CMD_PUT_S = 8'h05;
   localparam logic [7:0] CMD_SIZE  = 8'h06;
   localparam logic [7:0] CMD_FETCH = 8'h07;

   // access kinds
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   // register indexes
   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   localparam logic [7:0] WIDTH_RESET  = 8'd80;
   localparam logic [7:0] HEIGHT_RESET = 8'd25;

   typedef enum logic [2:0] {
      ACT_NONE  = 3'd0,
      ACT_CUR_X = 3'd1,
      ACT_CUR_Y = 3'd2,
      ACT_CUR_V = 3'd3,
      ACT_PUT_C = 3'd4,
      ACT_FETCH = 3'd5
   } action_type;

   typedef enum logic [10:0] {
      MODE_IDLE    = 11'b000_0000_0001,
      MODE_CUR_X   = 11'b000_0000_0010,
      MODE_CUR_Y   = 11'b000_0000_0100,
      MODE_CUR_V   = 11'b000_0000_1000,
      MODE_PUT_C   = 11'b000_0001_0000,
      MODE_PUT_S   = 11'b000_0010_0000,
      MODE_SIZE_W  = 11'b000_0100_0000,
      MODE_SIZE_H  = 11'b000_1000_0000,
      MODE_FETCH_X = 11'b001_0000_0000,
      MODE_FETCH_Y = 11'b010_0000_0000,
      MODE_FETCH   = 11'b100_0000_0000
   } mode_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] action_arg;
      logic [7:0] fetch_x;
      logic [7:0] fetch_y;
      logic [7:0] rd_data;
   } result_type;

endpackage

/* design/tpcd_if.sv */
`timescale 1ns / 1ps
// Channel interfaces for the terminal port command decoder.
// No dependencies.

interface tpcd_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] wr_byte;
   modport source (output valid, func, wr_byte, input ready);
   modport sink   (input valid, func, wr_byte, output ready);
endinterface

interface tpcd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [7:0] action_arg;
   logic [7:0] fetch_x;
   logic [7:0] fetch_y;
   logic [7:0] rd_data;
   modport source (output valid, action, action_arg, fetch_x, fetch_y, rd_data, input ready);
   modport sink   (input valid, action, action_arg, fetch_x, fetch_y, rd_data, output ready);
endinterface

interface tpcd_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* design/tpcd_decode.sv */
`timescale 1ns / 1ps
// Command sequencer: mode and saved fetch coordinates, result of one access.
// Depends on tpcd_pkg.

module tpcd_decode
   import tpcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       func,
   input  logic [7:0] wr_byte,
   input  logic [7:0] width,
   input  logic [7:0] height,
   output result_type result
);

   mode_type   mode_ff, mode_in;
   logic [7:0] saved_x_ff, saved_x_in;
   logic [7:0] saved_y_ff, saved_y_in;

   always_comb begin
      mode_in    = mode_ff;
      saved_x_in = saved_x_ff;
      saved_y_in = saved_y_ff;
      result     = '0;
      if (func == FUNC_READ) begin
         case (mode_ff)
            MODE_SIZE_W: begin
               result.rd_data = width;
               mode_in = MODE_SIZE_H;
            end
            MODE_SIZE_H: begin
               result.rd_data = height;
               mode_in = MODE_IDLE;
            end
            MODE_FETCH: begin
               result.action  = ACT_FETCH;
               result.fetch_x = saved_x_ff;
               result.fetch_y = saved_y_ff;
               mode_in = MODE_IDLE;
            end
            default: ;
         endcase
      end else if (wr_byte == CMD_RESET) begin
         mode_in = MODE_IDLE;
      end else begin
         case (mode_ff)
            MODE_IDLE: begin
               case (wr_byte)
                  CMD_CUR_X: mode_in = MODE_CUR_X;
                  CMD_CUR_Y: mode_in = MODE_CUR_Y;
                  CMD_CUR_V: mode_in = MODE_CUR_V;
                  CMD_PUT_C: mode_in = MODE_PUT_C;
                  CMD_PUT_S: mode_in = MODE_PUT_S;
                  CMD_SIZE:  mode_in = MODE_SIZE_W;
                  CMD_FETCH: mode_in = MODE_FETCH_X;
                  default: ;
               endcase
            end
            MODE_CUR_X: begin
               result.action     = ACT_CUR_X;
               result.action_arg = wr_byte;
               mode_in = MODE_IDLE;
            end
            MODE_CUR_Y: begin
               result.action     = ACT_CUR_Y;
               result.action_arg = wr_byte;
               mode_in = MODE_IDLE;
            end
            MODE_CUR_V: begin
               result.action     = ACT_CUR_V;
               result.action_arg = wr_byte;
               mode_in = MODE_IDLE;
            end
            MODE_PUT_C: begin
               result.action     = ACT_PUT_C;
               result.action_arg = wr_byte;
               mode_in = MODE_IDLE;
            end
            // stay in string mode until the reset byte
            MODE_PUT_S: begin
               result.action     = ACT_PUT_C;
               result.action_arg = wr_byte;
            end
            MODE_FETCH_X: begin
               saved_x_in = wr_byte;
               mode_in = MODE_FETCH_Y;
            end
            MODE_FETCH_Y: begin
               saved_y_in = wr_byte;
               mode_in = MODE_FETCH;
            end
            // drop writes while a read is pending
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         saved_x_ff <= '0;
         saved_y_ff <= '0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         saved_x_ff <= saved_x_in;
         saved_y_ff <= saved_y_in;
      end
   end

endmodule

/* design/tpcd_out_buf.sv */
`timescale 1ns / 1ps
// Result register with a skid stage, so the input side keeps flowing
// while the result side stalls. Depends on tpcd_pkg.

module tpcd_out_buf
   import tpcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  result_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff, out_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff, skid_data_in;
   logic       out_free;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign out_free  = !out_valid_ff || out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (in_valid && in_ready) begin
         if (out_free) begin
            out_valid_in = 1'b1;
            out_data_in  = in_data;
         end else begin
            // hold the new result until the output slot drains
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end else if (out_free) begin
         out_valid_in  = skid_valid_ff;
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

/* design/terminal_port_command_decoder.sv */
`timescale 1ns / 1ps
// Top level of the terminal port command decoder: size registers,
// sequencer and result buffer. Depends on tpcd_pkg, tpcd_if, tpcd_decode, tpcd_out_buf.
//
//   channel  role    payload
//   req_if   sink    func, wr_byte
//   rsp_if   source  action, action_arg, fetch_x, fetch_y, rd_data
//   csr_if   sink    index (0 width, 1 height), data
//
// One access per cycle while req_if.ready is high; its result is registered on acceptance.
// Every access gives exactly one result; the sequencer mode steps at acceptance.
// A stalled result is held in the output register, a second one in the skid stage;
// req_if.ready drops only while the skid stage is full.
// Reset (synchronous) returns to idle mode, width 80, height 25; csr writes always taken.

module terminal_port_command_decoder
   import tpcd_pkg::*;
(
   input logic         clock,
   input logic         reset,
   tpcd_req_if.sink    req_if,
   tpcd_rsp_if.source  rsp_if,
   tpcd_csr_if.sink    csr_if
);

   logic [7:0] width_ff;
   logic [7:0] height_ff;
   logic       req_ready;
   result_type result;
   result_type rsp_data;

   assign csr_if.ready = 1'b1;
   assign req_if.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_WIDTH:  width_ff  <= csr_if.data;
            CSR_HEIGHT: height_ff <= csr_if.data;
            default: ;
         endcase
      end
   end

   tpcd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_if.valid && req_ready),
      .func    (req_if.func),
      .wr_byte (req_if.wr_byte),
      .width   (width_ff),
      .height  (height_ff),
      .result  (result)
   );

   tpcd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_ready),
      .in_data   (result),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (rsp_data)
   );

   assign rsp_if.action     = rsp_data.action;
   assign rsp_if.action_arg = rsp_data.action_arg;
   assign rsp_if.fetch_x    = rsp_data.fetch_x;
   assign rsp_if.fetch_y    = rsp_data.fetch_y;
   assign rsp_if.rd_data    = rsp_data.rd_data;

endmodule
